// ===== hw/rtl/mf3_pkg.sv =====
`timescale 1ns / 1ps

package mf3_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Register reset values.
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	// Field widths fixed by the interface.
	localparam int IN_W       = 8;
	localparam int MED_W      = 8;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int OUT_W      = 32;
	localparam int FW_BITS    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Window size and depth of the queue between front and back.
	localparam int WIN_N   = 9;
	localparam int Q_DEPTH = 4;

	// Per-pixel job handed from the front to the back. Mask bits, lowest first:
	// upper row left, upper row right column, lower row left, lower row right column.
	typedef struct packed {
		logic [3:0]       mask;
		logic             lc;
		logic             w1;
		logic             y1;
		logic             y0;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} mf3_ctrl_t;

endpackage

// ===== hw/rtl/mf3_front.sv =====
`timescale 1ns / 1ps

module mf3_front #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mf3_pkg::IN_W-1:0]              s_tdata,
	output logic                                  q_push,
	output mf3_pkg::mf3_ctrl_t                    q_ctrl,
	output logic [mf3_pkg::WIN_N*PIXEL_BITS-1:0]  q_win,
	input  logic                                  q_full
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int PW    = PIXEL_BITS;
	localparam int RW    = mf3_pkg::ROW_W;
	localparam int EXT_W = 14;
	localparam int W_RST = (mf3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : mf3_pkg::WIDTH_RST;

	logic [XW-1:0] wlast_q, x_q, wlast_new;
	logic [RW-1:0] hlast_q, y_q, hlast_new;
	logic [EXT_W-1:0] fw;
	logic cfg_hit;

	logic accept, fire_s1;
	logic xpos, xlast, ypos, ylast;

	logic                v_s1;
	logic [PW-1:0]       pix_s1;
	logic [XW-1:0]       x_s1;
	mf3_pkg::mf3_ctrl_t  ctrl_s1;
	logic [2*PW-1:0]     rd_s1, fwd_d_s1;
	logic                fwd_s1;

	logic [2*PW-1:0] ent, wr_ent;
	logic [PW-1:0]   top, mid;
	logic [PW-1:0]   win_q  [mf3_pkg::WIN_N];
	logic [PW-1:0]   win_nx [mf3_pkg::WIN_N];

	// Each entry holds the two previous rows at one column: older row high, newer row low.
	logic [2*PW-1:0] line_mem [MAX_WIDTH];

	// Clamp the written width and height and keep them as last-index values.
	always_comb begin
		fw = EXT_W'(cfg_data[mf3_pkg::FW_BITS-1:0]);
		priority if (fw == '0) begin
			wlast_new = '0;
		end else if (fw > EXT_W'(MAX_WIDTH)) begin
			wlast_new = XW'(MAX_WIDTH - 1);
		end else begin
			wlast_new = XW'(fw - EXT_W'(1));
		end
		hlast_new = (cfg_data == '0) ? '0 : RW'(cfg_data - 1'b1);
	end

	assign cfg_hit = cfg_we && ((cfg_idx == mf3_pkg::REG_FRAME_WIDTH) ||
		(cfg_idx == mf3_pkg::REG_FRAME_HEIGHT));

	assign fire_s1  = v_s1 && ((ctrl_s1.mask == '0) || !q_full);
	assign q_push   = fire_s1 && (ctrl_s1.mask != '0);
	assign s_tready = !v_s1 || fire_s1;
	assign accept   = s_tvalid && s_tready;

	assign xpos  = x_q != '0;
	assign xlast = x_q == wlast_q;
	assign ypos  = y_q != '0;
	assign ylast = y_q == hlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= XW'(W_RST - 1);
			hlast_q <= RW'(mf3_pkg::HEIGHT_RST - 1);
			x_q     <= '0;
			y_q     <= '0;
			v_s1    <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == mf3_pkg::REG_FRAME_WIDTH) begin
				wlast_q <= wlast_new;
			end
			if (cfg_we && cfg_idx == mf3_pkg::REG_FRAME_HEIGHT) begin
				hlast_q <= hlast_new;
			end
			if (cfg_hit) begin
				x_q <= '0;
				y_q <= '0;
			end else if (accept) begin
				if (xlast) begin
					x_q <= '0;
					y_q <= ylast ? '0 : y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (accept) begin
				v_s1   <= 1'b1;
				fwd_s1 <= fire_s1 && (x_s1 == x_q);
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= PW'(s_tdata);
			x_s1         <= x_q;
			ctrl_s1.mask <= {ylast && xlast, ylast && xpos, ypos && xlast, ypos && xpos};
			ctrl_s1.lc   <= x_q == XW'(1);
			ctrl_s1.w1   <= wlast_q == '0;
			ctrl_s1.y1   <= y_q == RW'(1);
			ctrl_s1.y0   <= !ypos;
			ctrl_s1.col  <= mf3_pkg::COL_W'(x_q);
			ctrl_s1.row  <= y_q;
			fwd_d_s1     <= wr_ent;
		end
	end

	// Line store: read when a pixel is taken, written when it leaves the front stage.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			line_mem[x_s1] <= wr_ent;
		end
		if (accept) begin
			rd_s1 <= line_mem[x_q];
		end
	end

	// A read that met the write to the same column in the same cycle takes the new data.
	assign ent    = fwd_s1 ? fwd_d_s1 : rd_s1;
	assign top    = ent[2*PW-1:PW];
	assign mid    = ent[PW-1:0];
	assign wr_ent = {mid, pix_s1};

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			win_nx[i] = win_q[i+3];
		end
		win_nx[6] = top;
		win_nx[7] = mid;
		win_nx[8] = pix_s1;
		for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
			q_win[i*PW +: PW] = win_nx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
				win_q[i] <= '0;
			end
		end else if (fire_s1) begin
			for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
				win_q[i] <= win_nx[i];
			end
		end
	end

	assign q_ctrl = ctrl_s1;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n) x_q <= wlast_q)
		else $error("column counter ran past the row");
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n) y_q <= hlast_q)
		else $error("row counter ran past the frame");

endmodule

// ===== hw/rtl/mf3_fifo.sv =====
`timescale 1ns / 1ps

module mf3_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] dout
);

	localparam int DEPTH = mf3_pkg::Q_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = count_q == CW'(DEPTH);
	assign valid = count_q != '0;
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("job queue read while empty");

endmodule

// ===== hw/rtl/mf3_back.sv =====
`timescale 1ns / 1ps

module mf3_back #(
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  mf3_pkg::mf3_ctrl_t                    q_ctrl,
	input  logic [mf3_pkg::WIN_N*PIXEL_BITS-1:0]  q_win,
	output logic                                  q_pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mf3_pkg::OUT_W-1:0]             m_tdata,
	output logic                                  m_tlast
);

	localparam int PW = PIXEL_BITS;

	typedef struct packed {
		logic [mf3_pkg::COL_W-1:0] col;
		logic [mf3_pkg::ROW_W-1:0] row;
		logic                      done;
	} coord_t;

	function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
		input logic [PW-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	logic                     cur_v_q;
	mf3_pkg::mf3_ctrl_t       cur_ctrl_q;
	logic [mf3_pkg::WIN_N*PW-1:0] cur_win_q;

	logic       adv, gen, last, is_right, lower;
	logic [3:0] sel, rem;
	logic [1:0] cidx [3];
	logic [PW-1:0] win_c [3][3];
	logic [PW-1:0] gv [mf3_pkg::WIN_N];
	coord_t     gcrd;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [PW-1:0] val_s1 [mf3_pkg::WIN_N];
	logic [PW-1:0] lo_s2 [3];
	logic [PW-1:0] md_s2 [3];
	logic [PW-1:0] hi_s2 [3];
	logic [PW-1:0] a_s3, b_s3, c_s3, med_s4;
	coord_t crd_s1, crd_s2, crd_s3, crd_s4;

	// The whole median pipeline moves together unless the output word is held.
	assign adv  = !v_s4 || m_tready;
	assign gen  = cur_v_q && adv;
	assign sel  = cur_ctrl_q.mask & (~cur_ctrl_q.mask + 4'd1);
	assign rem  = cur_ctrl_q.mask & ~sel;
	assign last = rem == '0;
	assign q_pop = q_valid && (!cur_v_q || (gen && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
		end else if (gen && last) begin
			cur_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_ctrl_q <= q_ctrl;
			cur_win_q  <= q_win;
		end else if (gen) begin
			cur_ctrl_q.mask <= rem;
		end
	end

	// Pick the three window columns and the three rows of the result being issued.
	// Missing columns and rows at the frame edges repeat the nearest one.
	always_comb begin
		is_right = sel[1] || sel[3];
		lower    = sel[2] || sel[3];
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				win_c[c][r] = cur_win_q[(3*c+r)*PW +: PW];
			end
		end
		if (is_right) begin
			cidx[0] = cur_ctrl_q.w1 ? 2'd2 : 2'd1;
			cidx[1] = 2'd2;
		end else begin
			cidx[0] = cur_ctrl_q.lc ? 2'd1 : 2'd0;
			cidx[1] = 2'd1;
		end
		cidx[2] = 2'd2;
		for (int k = 0; k < 3; k++) begin
			if (lower) begin
				gv[3*k]   = cur_ctrl_q.y0 ? win_c[cidx[k]][2] : win_c[cidx[k]][1];
				gv[3*k+1] = win_c[cidx[k]][2];
				gv[3*k+2] = win_c[cidx[k]][2];
			end else begin
				gv[3*k]   = cur_ctrl_q.y1 ? win_c[cidx[k]][1] : win_c[cidx[k]][0];
				gv[3*k+1] = win_c[cidx[k]][1];
				gv[3*k+2] = win_c[cidx[k]][2];
			end
		end
		gcrd.col  = is_right ? cur_ctrl_q.col : cur_ctrl_q.col - 1'b1;
		gcrd.row  = lower ? cur_ctrl_q.row : cur_ctrl_q.row - 1'b1;
		gcrd.done = sel[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= gen;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Median of nine: sort each triple, then take the largest minimum, the median of
	// the middles and the smallest maximum, and finally the median of those three.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < mf3_pkg::WIN_N; i++) begin
				val_s1[i] <= gv[i];
			end
			crd_s1 <= gcrd;
			for (int k = 0; k < 3; k++) begin
				lo_s2[k] <= min2(min2(val_s1[3*k], val_s1[3*k+1]), val_s1[3*k+2]);
				md_s2[k] <= med3(val_s1[3*k], val_s1[3*k+1], val_s1[3*k+2]);
				hi_s2[k] <= max2(max2(val_s1[3*k], val_s1[3*k+1]), val_s1[3*k+2]);
			end
			crd_s2 <= crd_s1;
			a_s3   <= max2(max2(lo_s2[0], lo_s2[1]), lo_s2[2]);
			b_s3   <= med3(md_s2[0], md_s2[1], md_s2[2]);
			c_s3   <= min2(min2(hi_s2[0], hi_s2[1]), hi_s2[2]);
			crd_s3 <= crd_s2;
			med_s4 <= med3(a_s3, b_s3, c_s3);
			crd_s4 <= crd_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = mf3_pkg::OUT_W'({crd_s4.row, crd_s4.col, mf3_pkg::MED_W'(med_s4)});
	assign m_tlast  = crd_s4.done;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n) gen |-> $onehot(sel))
		else $error("issue slot does not select exactly one result");
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (cur_ctrl_q.mask != '0))
		else $error("held job has no results left");

endmodule

// ===== hw/rtl/median_filter_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 median filter for a grayscale pixel stream in raster order.
// Input words on s_* carry one pixel each; output words on m_* carry the median of
// the 3x3 neighborhood of one position with its column and row, and m_tlast marks
// the final output of a frame. Neighbors outside the frame repeat the edge pixel.
// The result for position (r, c) is released by pixel (r+1, c+1); the last pixel of
// a row also releases the last column, and pixels of the last row release their own
// row as well, so the final pixel of a frame releases four results.
// A result passes the front stage, job queue, held job and median stages s1 to s4.
// Throughput, unless stalled: one pixel per cycle, one line-store read and one write per
// pixel; the output gives one result per cycle from the median pipeline, so on the last
// row, where each pixel makes two results, input is taken at about half rate.
// frame_width and frame_height are written on cfg_* while the block is idle; a write
// restarts the frame at row 0, column 0. Width is clamped to 1..MAX_WIDTH, height
// to at least one row.
// Reset sets 640 x 480, clears the counters, window and queue. The line store is not
// cleared; no entry is read for a result before it was written in the current frame.
// When m_tready is low the output word holds, the median pipeline and job queue fill,
// and then s_tready drops.
module median_filter_3x3 #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mf3_pkg::IN_W-1:0]       s_tdata,  // [7:0] pixel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mf3_pkg::OUT_W-1:0]      m_tdata,  // [7:0] median, [17:8] out_col,
	                                                 // [29:18] out_row, [31:30] zero
	output logic                           m_tlast   // frame_done
);

	localparam int CTRL_W = $bits(mf3_pkg::mf3_ctrl_t);
	localparam int WIN_W  = mf3_pkg::WIN_N * PIXEL_BITS;
	localparam int Q_W    = CTRL_W + WIN_W;

	logic               q_push, q_full, q_pop, q_valid;
	mf3_pkg::mf3_ctrl_t q_ctrl_wr, q_ctrl_rd;
	logic [WIN_W-1:0]   q_win_wr, q_win_rd;
	logic [Q_W-1:0]     q_dout;

	// Front: counters, line store and window; emits one job per pixel that makes results.
	mf3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_push   (q_push),
		.q_ctrl   (q_ctrl_wr),
		.q_win    (q_win_wr),
		.q_full   (q_full)
	);

	// Short job queue so the front and the back can stall independently.
	mf3_fifo #(
		.WIDTH (Q_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({q_ctrl_wr, q_win_wr}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	assign q_ctrl_rd = q_dout[Q_W-1 -: CTRL_W];
	assign q_win_rd  = q_dout[WIN_W-1:0];

	// Back: issues each job's results one per cycle through the median pipeline unless held.
	mf3_back #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ctrl   (q_ctrl_rd),
		.q_win    (q_win_rd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== tb/sv/median_checker.sv =====
`timescale 1ns / 1ps

module median_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [mf3_pkg::IN_W-1:0]       s_tdata,  // [7:0] pixel
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [mf3_pkg::OUT_W-1:0]      m_tdata,  // [7:0] median, [17:8] out_col,
	                                                 // [29:18] out_row, [31:30] zero
	input  logic                           m_tlast,  // frame_done
	output int                             fail_count,
	output int                             pending_words
);
	import mf3_pkg::*;

	localparam int LINE_LEN    = MAX_WIDTH_DEF;
	localparam int REPORT_MAX  = 50;

	typedef struct packed {
		logic [MED_W-1:0] median;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             done;
	} filtered_pixel_t;

	logic [FW_BITS-1:0] frame_width;
	logic [ROW_W-1:0]   frame_height;
	logic [MED_W-1:0]   older_row [LINE_LEN];
	logic [MED_W-1:0]   newer_row [LINE_LEN];
	logic [MED_W-1:0]   win [WIN_N];
	int                 col_pos;
	int                 row_pos;
	int                 errors;
	filtered_pixel_t    expected_words [$];

	function automatic logic [MED_W-1:0] median_of_nine(input logic [MED_W-1:0] vals [9]);
		logic [MED_W-1:0] s [9];
		logic [MED_W-1:0] t;
		int               i;
		int               j;
		s = vals;
		for (i = 0; i < 8; i++) begin
			for (j = 0; j < 8 - i; j++) begin
				if (s[j] > s[j + 1]) begin
					t        = s[j];
					s[j]     = s[j + 1];
					s[j + 1] = t;
				end
			end
		end
		return s[4];
	endfunction

	// Window column k keeps rows y-2, y-1, y in win[3k..3k+2]. With lower set the
	// centre row is the current one (last row of the frame), else the row above.
	task automatic queue_result(input int lc, input int cc, input bit lower, input int y,
			input int col, input int row, input bit done);
		logic [MED_W-1:0] vals [9];
		int               cols [3];
		int               k;
		int               b;
		filtered_pixel_t  word;
		cols[0] = lc;
		cols[1] = cc;
		cols[2] = 2;
		for (k = 0; k < 3; k++) begin
			b = 3 * cols[k];
			if (!lower) begin
				vals[3 * k]     = (y == 1) ? win[b + 1] : win[b];
				vals[3 * k + 1] = win[b + 1];
				vals[3 * k + 2] = win[b + 2];
			end else begin
				vals[3 * k]     = (y == 0) ? win[b + 2] : win[b + 1];
				vals[3 * k + 1] = win[b + 2];
				vals[3 * k + 2] = win[b + 2];
			end
		end
		word.median = median_of_nine(vals);
		word.col    = col[COL_W-1:0];
		word.row    = row[ROW_W-1:0];
		word.done   = done;
		expected_words.push_back(word);
	endtask

	task automatic take_pixel(input logic [IN_W-1:0] pix);
		int               w;
		int               h;
		int               x;
		int               y;
		int               k;
		int               lc;
		int               last_lc;
		logic [MED_W-1:0] top;
		logic [MED_W-1:0] mid;
		w = frame_width;
		h = frame_height;
		if (w == 0) w = 1;
		if (w > LINE_LEN) w = LINE_LEN;
		if (h == 0) h = 1;
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		y = row_pos;

		top          = older_row[x];
		mid          = newer_row[x];
		older_row[x] = mid;
		newer_row[x] = pix;
		for (k = 0; k < 6; k++)
			win[k] = win[k + 3];
		win[6] = top;
		win[7] = mid;
		win[8] = pix;

		// Left and right edges repeat the edge column.
		lc      = (x == 1) ? 1 : 0;
		last_lc = (w == 1) ? 2 : 1;
		if (y >= 1) begin
			if (x >= 1) queue_result(lc, 1, 1'b0, y, x - 1, y - 1, 1'b0);
			if (x == w - 1) queue_result(last_lc, 2, 1'b0, y, x, y - 1, 1'b0);
		end
		if (y == h - 1) begin
			if (x >= 1) queue_result(lc, 1, 1'b1, y, x - 1, y, 1'b0);
			if (x == w - 1) queue_result(last_lc, 2, 1'b1, y, x, y, 1'b1);
		end

		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= REPORT_MAX)
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	task automatic check_word();
		filtered_pixel_t want;
		if (expected_words.size() == 0) begin
			errors++;
			if (errors <= REPORT_MAX)
				$error("output word %h (last %b) arrived with no result expected",
					m_tdata, m_tlast);
		end else begin
			want = expected_words.pop_front();
			compare_field("median", want.median, m_tdata[MED_W-1:0]);
			compare_field("out_col", want.col, m_tdata[MED_W+COL_W-1:MED_W]);
			compare_field("out_row", want.row, m_tdata[MED_W+COL_W+ROW_W-1:MED_W+COL_W]);
			compare_field("frame_done", want.done, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width  = WIDTH_RST;
			frame_height = HEIGHT_RST;
			for (int i = 0; i < LINE_LEN; i++) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			for (int i = 0; i < WIN_N; i++)
				win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
			expected_words.delete();
		end else begin
			// Writes to either register restart the frame; other indexes do nothing.
			if (cfg_we) begin
				case (cfg_idx)
					REG_FRAME_WIDTH: begin
						frame_width = cfg_data[FW_BITS-1:0];
						col_pos     = 0;
						row_pos     = 0;
					end
					REG_FRAME_HEIGHT: begin
						frame_height = cfg_data[ROW_W-1:0];
						col_pos      = 0;
						row_pos      = 0;
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_pixel(s_tdata);
			if (m_tvalid && m_tready)
				check_word();
		end
		fail_count    <= errors;
		pending_words <= expected_words.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the 3x3 median filter. The checker beside the block
// predicts every output word from the words it sees taken on the input and
// configuration ports; this module only drives the ports and decides the outcome.
module testbench;
	import mf3_pkg::*;

	localparam int RESET_CYCLES   = 10;
	// Enough to be sure that the median pipeline is empty.
	localparam int SETTLE_CYCLES  = 16;
	// Long enough for the job queue and pipeline to fill and stall the input.
	localparam int HOLD_CYCLES    = 300;
	// Cycles with no word accepted on either side before the run is given up.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS  = 180;

	// Indexes past the register list; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// A 3x3 frame of extreme, near-extreme and mid levels.
	localparam logic [IN_W-1:0] GRID_3X3 [9] = '{
		8'h00, 8'hFF, 8'h00,
		8'hFF, 8'h80, 8'h7F,
		8'h01, 8'hFE, 8'hFF
	};

	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_NARROW, PIX_RAMP} pixel_style_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tlast;

	int fail_count;
	int pending_words;
	int idle_cycles = 0;

	// Traffic shaping knobs, changed between phases by the main sequence.
	bit in_gaps    = 1'b0;
	bit out_stalls = 1'b0;
	bit hold_req   = 1'b0;

	always #1 clk = ~clk;

	median_filter_3x3 DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	median_checker median_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	// Lengths of gaps and stalls: mostly short, now and then a long one.
	function automatic int stretch_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (!in_gaps) return 0;
		return ($urandom_range(0, 1) == 0) ? 0 : stretch_len();
	endfunction

	function automatic logic [IN_W-1:0] make_pixel(input pixel_style_t style, input int i);
		case (style)
			PIX_EXTREME: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
			// A narrow band of levels gives many ties inside the window.
			PIX_NARROW:  return IN_W'(126 + $urandom_range(0, 3));
			PIX_RAMP:    return IN_W'(i * 37);
			default:     return IN_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one pixel and returns at the edge where it is taken. The valid stays
	// high so that back-to-back words need no second assignment in one step.
	task automatic send_pixel(input logic [IN_W-1:0] pix);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic feed_pixels(input int count, input pixel_style_t style);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(style, i));
		s_tvalid <= 1'b0;
	endtask

	// Waits until every predicted word has come out, then lets the pipeline empty,
	// since pixels of the first row release nothing and may still be in flight.
	// Values are read at the falling edge, where the checker outputs have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words != 0) @(negedge clk);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// The run ends here if nothing is accepted on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Output side: always ready, randomly stalling, or one long hold-off on request.
	initial begin
		int len;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!out_stalls) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 2) != 0);
				len = stretch_len();
				repeat (len) @(posedge clk);
			end
		end
	end

	initial begin
		int w;
		int h;
		int area;
		int count;
		int random_pixels;
		random_pixels = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Two pixels under the reset geometry of 640 x 480 release
		// nothing; the following register writes restart the frame.
		send_pixel(8'h00);
		send_pixel(8'hFF);
		s_tvalid <= 1'b0;

		// Zero width and zero height behave as a 1x1 frame, so one pixel yields
		// a single result, which marks the end of the frame.
		configure(12'd0, 12'd0);
		send_pixel(8'hFF);
		s_tvalid <= 1'b0;

		// A full 3x3 frame covers every border case of the clamped window.
		configure(12'd3, 12'd3);
		for (int i = 0; i < 9; i++)
			send_pixel(GRID_3X3[i]);
		s_tvalid <= 1'b0;

		// Writes to unused indexes in the middle of a 2x2 frame must not restart it.
		configure(12'd2, 12'd2);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		s_tvalid <= 1'b0;
		wait_drained();
		write_reg(REG_SPARE_A, 12'hFFF);
		write_reg(REG_SPARE_B, 12'h001);
		send_pixel(8'h01);
		send_pixel(8'hFE);
		s_tvalid <= 1'b0;

		// Extreme geometries with random traffic on both sides. A width above the
		// line length saturates, so 2047 is taken as 1024; the start of its single
		// row is sent.
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
		configure(12'd2047, 12'd1);
		feed_pixels(48, PIX_RANDOM);
		configure(12'd1, 12'd4095);
		feed_pixels(24, PIX_RANDOM);
		// The width register is only 11 bits wide, so the top data bit is dropped.
		configure(12'h803, 12'd2);
		feed_pixels(6, PIX_RAMP);

		// Back-pressure: the receiver holds off while the sender keeps offering
		// words until the block fills up and refuses input.
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		configure(12'd16, 12'd8);
		hold_req = 1'b1;
		feed_pixels(64, PIX_RANDOM);

		// Random part: small frames, mostly whole ones, sometimes cut short so that
		// the next register write restarts a frame in progress.
		while (random_pixels < RANDOM_PIXELS) begin
			w     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			h     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			area  = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area)
				: area * $urandom_range(1, 2);
			in_gaps    = ($urandom_range(0, 3) != 0);
			out_stalls = ($urandom_range(0, 3) != 0);
			configure(w[CFG_DATA_W-1:0], h[CFG_DATA_W-1:0]);
			feed_pixels(count, pixel_style_t'($urandom_range(0, 3)));
			random_pixels += count;
		end

		wait_drained();
		@(negedge clk);
		if (fail_count == 0 && pending_words == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
